>>> rtl/adagrad_parameter_update_top_macros.svh
// assertion macros for the adaptive gradient update block
`ifndef ADAGRAD_PARAMETER_UPDATE_TOP_MACROS_SVH
`define ADAGRAD_PARAMETER_UPDATE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define AGP_ASSERT_IMP(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
    else $error("assertion failed");
`define AGP_ASSERT_NXT(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define AGP_ASSERT_IMP(lbl, ck, rn, a, c)
`define AGP_ASSERT_NXT(lbl, ck, rn, a, c)
`endif
`endif

>>> rtl/agp_pkg.sv
package agp_pkg;

  localparam int DATA_W    = 32;
  localparam int SLOTS_DEF = 4096;
  localparam int FRAC_DEF  = 16;
  localparam int SLOT_IN_W = 12;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 3;
  localparam int FLOOR_W   = 31;
  localparam int MODE_W    = 4;

  localparam logic [OP_W-1:0] OP_MEAN  = 2'd0;
  localparam logic [OP_W-1:0] OP_VAR   = 2'd1;
  localparam logic [OP_W-1:0] OP_TABLE = 2'd2;
  localparam logic [OP_W-1:0] OP_DIST  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE_GEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MEAN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_COV  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_W_MEAN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_W_COV     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd6;

  localparam int MODE_ADAPT = 0;
  localparam int MODE_VAR   = 1;
  localparam int MODE_TABLE = 2;
  localparam int MODE_DIST  = 3;

  localparam logic [DATA_W-1:0]  RATE_RST   = 32'd655;
  localparam logic [DATA_W-1:0]  WEIGHT_RST = 32'd65536;
  localparam logic [FLOOR_W-1:0] FLOOR_RST  = 31'd66;
  localparam logic [MODE_W-1:0]  MODE_RST   = 4'd3;

  localparam int SQ_IN_W   = 64;
  localparam int SQ_OUT_W  = 32;
  localparam int SQ_REM_W  = 34;
  localparam int STEP_BITS = 2;

endpackage

>>> rtl/agp_div.sv
module agp_div #(
  parameter int QW = agp_pkg::DATA_W + agp_pkg::FRAC_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [QW-1:0]              dvd,
  input  logic [agp_pkg::DATA_W-1:0] dvs,
  output logic [QW-1:0]              quo
);
  import agp_pkg::*;

  localparam int NST = (QW + STEP_BITS - 1) / STEP_BITS;
  localparam int PW  = NST * STEP_BITS;

  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [PW-1:0]     acc;
    logic [DATA_W-1:0] d;
  } div_st_t;

  div_st_t st_r [NST];
  div_st_t st_in;

  function automatic div_st_t div_stage(div_st_t s);
    div_st_t o;
    logic [DATA_W:0] t;
    o = s;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {o.rem, o.acc[PW-1]};
      o.acc = {o.acc[PW-2:0], 1'b0};
      if (t >= {1'b0, o.d}) begin
        o.rem = DATA_W'(t - {1'b0, o.d});
        o.acc[0] = 1'b1;
      end else begin
        o.rem = t[DATA_W-1:0];
      end
    end
    return o;
  endfunction

  always_comb begin
    st_in.rem = '0;
    st_in.acc = PW'(dvd);
    st_in.d   = dvs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= div_stage(st_in);
      for (int k = 1; k < NST; k++) begin
        st_r[k] <= div_stage(st_r[k-1]);
      end
    end
  end

  assign quo = st_r[NST-1].acc[QW-1:0];

endmodule

>>> rtl/agp_sqrt.sv
module agp_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [agp_pkg::SQ_IN_W-1:0]  rad,
  output logic [agp_pkg::SQ_OUT_W-1:0] root
);
  import agp_pkg::*;

  localparam int NST = SQ_OUT_W / STEP_BITS;
  localparam int TW  = SQ_REM_W + 2;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_OUT_W-1:0] res;
    logic [SQ_IN_W-1:0]  v;
  } sq_st_t;

  sq_st_t st_r [NST];
  sq_st_t st_in;

  function automatic sq_st_t sq_stage(sq_st_t s);
    sq_st_t o;
    logic [TW-1:0] t;
    logic [TW-1:0] trial;
    o = s;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {o.rem, o.v[SQ_IN_W-1 -: 2]};
      o.v = {o.v[SQ_IN_W-3:0], 2'b00};
      trial = {(SQ_REM_W - SQ_OUT_W)'(0), o.res, 2'b01};
      if (t >= trial) begin
        o.rem = SQ_REM_W'(t - trial);
        o.res = {o.res[SQ_OUT_W-2:0], 1'b1};
      end else begin
        o.rem = t[SQ_REM_W-1:0];
        o.res = {o.res[SQ_OUT_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  always_comb begin
    st_in.rem = '0;
    st_in.res = '0;
    st_in.v   = rad;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= sq_stage(st_in);
      for (int k = 1; k < NST; k++) begin
        st_r[k] <= sq_stage(st_r[k-1]);
      end
    end
  end

  assign root = st_r[NST-1].res;

endmodule

>>> rtl/agp_store.sv
module agp_store #(
  parameter int SLOTS     = agp_pkg::SLOTS_DEF,
  parameter int FRAC_BITS = agp_pkg::FRAC_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [$clog2(SLOTS)-1:0]   rd_addr,
  output logic [agp_pkg::DATA_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(SLOTS)-1:0]   wr_addr,
  input  logic [agp_pkg::DATA_W-1:0] wr_data,
  output logic                       clearing
);
  import agp_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

  logic [DATA_W-1:0] mem [SLOTS];
  logic [DATA_W-1:0] rd_data_r;
  logic [SW-1:0]     clr_cnt_r;
  logic              clearing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      if (clr_cnt_r == SW'(SLOTS - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_cnt_r <= SW'(clr_cnt_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_cnt_r] <= ONE;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clearing_r;

endmodule

>>> rtl/adagrad_parameter_update_top.sv
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_stall    | operation, slot, current, numerator, denominator
// out     | output    | out_valid / out_stall  | new_value, limited
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one item per cycle while no stall holds the pipeline; Q16.16 by default (FRAC_BITS = 16),
// and the pipeline length is set by the radix-4 rate divider
// an item whose slot matches a scale update still in flight waits in the first
// stage until that update is written back at the end of the square root pipeline
// after reset the scale store is filled with 1.0, with in_stall high
// out_stall with out_valid high freezes the whole pipeline; cfg_ready is always high
`include "adagrad_parameter_update_top_macros.svh"
module adagrad_parameter_update_top #(
  parameter int SLOTS     = agp_pkg::SLOTS_DEF,
  parameter int FRAC_BITS = agp_pkg::FRAC_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [agp_pkg::OP_W-1:0]            in_operation,
  input  logic [agp_pkg::SLOT_IN_W-1:0]       in_slot,
  input  logic signed [agp_pkg::DATA_W-1:0]   in_current_value,
  input  logic signed [agp_pkg::DATA_W-1:0]   in_numerator_acc,
  input  logic signed [agp_pkg::DATA_W-1:0]   in_denominator_acc,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [agp_pkg::DATA_W-1:0]   out_new_value,
  output logic                                out_limited,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [agp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [agp_pkg::DATA_W-1:0]          cfg_data
);
  import agp_pkg::*;

  localparam int SW       = $clog2(SLOTS);
  localparam int QW       = DATA_W + FRAC_BITS;
  localparam int DIV_ST   = (QW + STEP_BITS - 1) / STEP_BITS;
  localparam int SQ_ST    = SQ_OUT_W / STEP_BITS;
  localparam int ST_DIV   = 2;
  localparam int ST_SQ    = 6;
  localparam int ST_WB    = ST_SQ + SQ_ST;
  localparam int ST_RATE  = ST_DIV + DIV_ST + 1;
  localparam int ST_LAST  = ST_RATE + 1;
  localparam int KQ       = SLOT_IN_W + SW;
  localparam int QPW      = SLOT_IN_W + KQ;
  localparam int PW       = 2 * DATA_W + 1;
  localparam int GW       = 2 * DATA_W + 2;
  localparam int DW2      = 2 * DATA_W;
  localparam logic [63:0] RECIP = ((64'd1 << KQ) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [SW-1:0]            addr;
    logic                     en;
    logic                     wr;
    logic signed [DATA_W-1:0] cur;
    logic signed [DATA_W-1:0] num;
    logic signed [DATA_W-1:0] den;
    logic [DATA_W-1:0]        rate;
    logic signed [DATA_W-1:0] g;
    logic                     ghit;
  } meta_t;

  // configuration
  logic [DATA_W-1:0]  rate_gen_r, rate_mean_r, rate_cov_r, w_mean_r, w_cov_r;
  logic [FLOOR_W-1:0] floor_r;
  logic [MODE_W-1:0]  mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_gen_r  <= RATE_RST;
      rate_mean_r <= RATE_RST;
      rate_cov_r  <= RATE_RST;
      w_mean_r    <= WEIGHT_RST;
      w_cov_r     <= WEIGHT_RST;
      floor_r     <= FLOOR_RST;
      mode_r      <= MODE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RATE_GEN:  rate_gen_r  <= cfg_data;
        CFG_RATE_MEAN: rate_mean_r <= cfg_data;
        CFG_RATE_COV:  rate_cov_r  <= cfg_data;
        CFG_W_MEAN:    w_mean_r    <= cfg_data;
        CFG_W_COV:     w_cov_r     <= cfg_data;
        CFG_FLOOR:     floor_r     <= cfg_data[FLOOR_W-1:0];
        CFG_MODE:      mode_r      <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // pipeline control
  logic adv, hz, ld1, s1_move, acc_in;
  logic st_clearing;
  logic out_valid_r;
  logic [ST_LAST:2] vld_r;
  meta_t pl_r [2:ST_LAST];

  assign adv = !out_valid_r || !out_stall;

  // stage 1
  logic                     s1_vld_r;
  logic [OP_W-1:0]          s1_op_r;
  logic [SLOT_IN_W-1:0]     s1_slot_r, s1_q_r;
  logic signed [DATA_W-1:0] s1_cur_r, s1_num_r, s1_den_r;
  logic                     s1_en_r;
  logic                     in_en;
  logic [QPW-1:0]           qprod;
  logic [DATA_W-1:0]        s1_rem;
  logic [SW-1:0]            s1_addr;
  logic                     s1_wr;
  logic [DATA_W-1:0]        s1_rate;

  always_comb begin
    unique case (in_operation)
      OP_MEAN:  in_en = 1'b1;
      OP_VAR:   in_en = mode_r[MODE_VAR];
      OP_TABLE: in_en = mode_r[MODE_TABLE];
      OP_DIST:  in_en = mode_r[MODE_DIST];
    endcase
  end

  assign qprod = QPW'(in_slot) * QPW'(RECIP[KQ-1:0]);
  assign s1_rem  = DATA_W'(s1_slot_r) - DATA_W'(s1_q_r) * DATA_W'(SLOTS);
  assign s1_addr = s1_rem[SW-1:0];
  assign s1_wr   = s1_en_r && mode_r[MODE_ADAPT];

  always_comb begin
    unique case (s1_op_r)
      OP_MEAN:  s1_rate = rate_mean_r;
      OP_VAR:   s1_rate = rate_cov_r;
      OP_TABLE: s1_rate = rate_gen_r;
      OP_DIST:  s1_rate = rate_gen_r;
    endcase
  end

  always_comb begin
    hz = 1'b0;
    for (int k = 2; k <= ST_WB; k++) begin
      if (vld_r[k] && pl_r[k].wr && (pl_r[k].addr == s1_addr)) begin
        hz = 1'b1;
      end
    end
    hz = hz && s1_wr;
  end

  assign s1_move  = s1_vld_r && adv && !hz;
  assign ld1      = !s1_vld_r || s1_move;
  assign in_stall = st_clearing || !ld1;
  assign acc_in   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (acc_in) begin
      s1_op_r   <= in_operation;
      s1_slot_r <= in_slot;
      s1_q_r    <= qprod[QPW-1:KQ];
      s1_cur_r  <= in_current_value;
      s1_num_r  <= in_numerator_acc;
      s1_den_r  <= in_denominator_acc;
      s1_en_r   <= in_en;
    end
  end

  // scale store
  logic [DATA_W-1:0]   sc_rd;
  logic [SQ_OUT_W-1:0] root;
  logic                st_wr_en;

  assign st_wr_en = adv && vld_r[ST_WB] && pl_r[ST_WB].wr;

  agp_store #(
    .SLOTS     (SLOTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (s1_move),
    .rd_addr  (s1_addr),
    .rd_data  (sc_rd),
    .wr_en    (st_wr_en),
    .wr_addr  (pl_r[ST_WB].addr),
    .wr_data  (root),
    .clearing (st_clearing)
  );

  // gradient and sum of squares
  logic [DATA_W-1:0]        w2;
  logic signed [PW-1:0]     prod_nxt, prod_r, ws;
  logic [DATA_W-1:0]        sc3_r;
  logic signed [GW-1:0]     gw;
  logic signed [DATA_W-1:0] g_nxt;
  logic                     ghit_nxt;
  logic [DATA_W-1:0]        ag_nxt, ag_r;
  logic [DW2-1:0]           sa_r, sa5_r, sb_r, sum_r;
  logic [DW2:0]             sum_w;
  meta_t                    p4_nxt;

  assign w2       = (pl_r[2].op == OP_MEAN) ? w_mean_r : w_cov_r;
  assign prod_nxt = $signed({1'b0, w2}) * pl_r[2].den;
  assign ws       = prod_r >>> FRAC_BITS;

  always_comb begin
    if ((pl_r[3].op == OP_MEAN) || (pl_r[3].op == OP_VAR)) begin
      gw = GW'(pl_r[3].num) - GW'(ws);
    end else begin
      gw = GW'(pl_r[3].num) - GW'(pl_r[3].den);
    end
    ghit_nxt = (gw[GW-1:DATA_W-1] != '0) && (gw[GW-1:DATA_W-1] != '1);
    if (ghit_nxt) begin
      g_nxt = gw[GW-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      g_nxt = gw[DATA_W-1:0];
    end
    ag_nxt = g_nxt[DATA_W-1] ? DATA_W'(~g_nxt + 1'b1) : DATA_W'(g_nxt);
  end

  always_comb begin
    p4_nxt      = pl_r[3];
    p4_nxt.g    = g_nxt;
    p4_nxt.ghit = ghit_nxt;
  end

  assign sum_w = {1'b0, sa5_r} + {1'b0, sb_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      sc3_r  <= sc_rd;
      sa_r   <= DW2'(sc3_r) * DW2'(sc3_r);
      ag_r   <= ag_nxt;
      sb_r   <= DW2'(ag_r) * DW2'(ag_r);
      sa5_r  <= sa_r;
      sum_r  <= sum_w[DW2] ? '1 : sum_w[DW2-1:0];
    end
  end

  agp_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (sum_r),
    .root (root)
  );

  // adaptive rate
  logic [QW-1:0]     quo;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W-1:0] rr_nxt, rr_r;

  assign dvs = (sc_rd == '0) ? DATA_W'(1) : sc_rd;

  agp_div #(
    .QW (QW)
  ) u_div (
    .clk (clk),
    .en  (adv),
    .dvd ({pl_r[ST_DIV].rate, {FRAC_BITS{1'b0}}}),
    .dvs (dvs),
    .quo (quo)
  );

  always_comb begin
    if (mode_r[MODE_ADAPT]) begin
      rr_nxt = (|quo[QW-1:DATA_W]) ? '1 : quo[DATA_W-1:0];
    end else begin
      rr_nxt = pl_r[ST_RATE-1].rate;
    end
  end

  // step and limits
  logic signed [PW-1:0]     prod2_r, step;
  logic signed [GW-1:0]     nvw, nv;
  logic                     hit;
  logic signed [DATA_W-1:0] new_nxt;
  logic                     lim_nxt;
  meta_t                    mo;

  assign mo   = pl_r[ST_LAST];
  assign step = prod2_r >>> FRAC_BITS;
  assign nvw  = GW'(mo.cur) + GW'(step);

  always_comb begin
    hit = mo.ghit;
    nv  = nvw;
    if ((mo.op == OP_VAR) && (nvw < $signed(GW'(floor_r)))) begin
      nv  = $signed(GW'(floor_r));
      hit = 1'b1;
    end
    if (((mo.op == OP_TABLE) || (mo.op == OP_DIST)) && (nvw < 0)) begin
      nv  = '0;
      hit = 1'b1;
    end
    if ((nv[GW-1:DATA_W-1] != '0) && (nv[GW-1:DATA_W-1] != '1)) begin
      new_nxt = nv[GW-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      hit     = 1'b1;
    end else begin
      new_nxt = nv[DATA_W-1:0];
    end
    lim_nxt = hit;
    if (!mo.en) begin
      new_nxt = mo.cur;
      lim_nxt = 1'b0;
    end
  end

  // meta pipeline and output register
  logic signed [DATA_W-1:0] out_new_r;
  logic                     out_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) begin
        s1_vld_r <= acc_in;
      end
      if (adv) begin
        vld_r[2] <= s1_vld_r && !hz;
        for (int k = 3; k <= ST_LAST; k++) begin
          vld_r[k] <= vld_r[k-1];
        end
        out_valid_r <= vld_r[ST_LAST];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pl_r[2].op   <= s1_op_r;
      pl_r[2].addr <= s1_addr;
      pl_r[2].en   <= s1_en_r;
      pl_r[2].wr   <= s1_wr;
      pl_r[2].cur  <= s1_cur_r;
      pl_r[2].num  <= s1_num_r;
      pl_r[2].den  <= s1_den_r;
      pl_r[2].rate <= s1_rate;
      pl_r[2].g    <= '0;
      pl_r[2].ghit <= 1'b0;
      pl_r[3]      <= pl_r[2];
      pl_r[4]      <= p4_nxt;
      for (int k = 5; k <= ST_LAST; k++) begin
        pl_r[k] <= pl_r[k-1];
      end
      rr_r         <= rr_nxt;
      prod2_r      <= $signed({1'b0, rr_r}) * pl_r[ST_RATE].g;
      out_new_r    <= new_nxt;
      out_lim_r    <= lim_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_value = out_new_r;
  assign out_limited   = out_lim_r;

  `AGP_ASSERT_IMP(a_clear_stalls, clk, rst_n, st_clearing, in_stall)
  `AGP_ASSERT_IMP(a_no_wr_in_clear, clk, rst_n, st_wr_en, !st_clearing)
  `AGP_ASSERT_IMP(a_no_rd_wr_clash, clk, rst_n, (s1_move && s1_wr && st_wr_en), (s1_addr != pl_r[ST_WB].addr))
  `AGP_ASSERT_NXT(a_clear_once, clk, rst_n, !st_clearing, !st_clearing)

endmodule

>>> sim/tb_adagrad_parameter_update_top.sv
`timescale 1ns / 1ps

module tb_adagrad_parameter_update_top;
  import agp_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_value;
    logic                     limited;
  } upd_t;

  localparam int FRAC      = FRAC_DEF;
  localparam int DRAIN_CYC = 40;
  localparam int WD_LIMIT  = 20000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall;
  logic [OP_W-1:0] in_operation;
  logic [SLOT_IN_W-1:0] in_slot;
  logic signed [DATA_W-1:0] in_current_value, in_numerator_acc, in_denominator_acc;
  logic out_valid, out_stall;
  logic signed [DATA_W-1:0] out_new_value;
  logic out_limited;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  // predictor state
  logic [31:0] m_rate_gen, m_rate_mean, m_rate_cov, m_w_mean, m_w_cov;
  logic [FLOOR_W-1:0] m_floor;
  logic [MODE_W-1:0] m_mode;
  logic [31:0] scale_mem [SLOTS_DEF];

  upd_t pending_updates[$];
  int fail_count = 0;
  int stall_mode = 0;
  int gap_max = 0;
  int burst_left = 0;
  int cyc = 0;
  int idle_cyc = 0;

  adagrad_parameter_update_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_slot(in_slot),
    .in_current_value(in_current_value), .in_numerator_acc(in_numerator_acc),
    .in_denominator_acc(in_denominator_acc),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_new_value(out_new_value), .out_limited(out_limited),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic upd_t predict_update(logic [OP_W-1:0] op, logic [SLOT_IN_W-1:0] slot,
                                          logic signed [31:0] cur, logic signed [31:0] num,
                                          logic signed [31:0] den);
    upd_t res;
    bit enabled, hit;
    longint g, nv, wd, rate, rl;
    logic [63:0] sc, ag, a, b, r, v, root, bitv;
    logic [64:0] sum;
    hit = 0;
    case (op)
      OP_MEAN: enabled = 1;
      OP_VAR:  enabled = m_mode[MODE_VAR];
      OP_TABLE: enabled = m_mode[MODE_TABLE];
      default: enabled = m_mode[MODE_DIST];
    endcase
    if (!enabled) begin
      res.new_value = cur;
      res.limited = 0;
      return res;
    end
    if (op == OP_MEAN) begin
      wd = longint'({32'b0, m_w_mean}) * longint'(den);
      g = longint'(num) - (wd >>> FRAC);
      rate = {32'b0, m_rate_mean};
    end else if (op == OP_VAR) begin
      wd = longint'({32'b0, m_w_cov}) * longint'(den);
      g = longint'(num) - (wd >>> FRAC);
      rate = {32'b0, m_rate_cov};
    end else begin
      g = longint'(num) - longint'(den);
      rate = {32'b0, m_rate_gen};
    end
    if (g > 64'sd2147483647) begin g = 64'sd2147483647; hit = 1; end
    if (g < -64'sd2147483648) begin g = -64'sd2147483648; hit = 1; end
    if (m_mode[MODE_ADAPT]) begin
      sc = {32'b0, scale_mem[slot]};
      ag = (g < 0) ? -g : g;
      a = sc * sc;
      b = ag * ag;
      sum = {1'b0, a} + {1'b0, b};
      v = sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
      r = (64'(rate) << FRAC) / ((sc != 0) ? sc : 64'd1);
      if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v = v - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      scale_mem[slot] = root[31:0];
      rl = longint'(r);
    end else begin
      rl = rate;
    end
    nv = longint'(cur) + ((rl * g) >>> FRAC);
    if (op == OP_VAR && nv < longint'({33'b0, m_floor})) begin
      nv = {33'b0, m_floor};
      hit = 1;
    end
    if (op >= OP_TABLE && nv < 0) begin nv = 0; hit = 1; end
    if (nv > 64'sd2147483647) begin nv = 64'sd2147483647; hit = 1; end
    if (nv < -64'sd2147483648) begin nv = -64'sd2147483648; hit = 1; end
    res.new_value = nv[31:0];
    res.limited = hit;
    return res;
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom_range(0, 32'h4_0000);
      4: return -$urandom_range(0, 32'h4_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, logic [SLOT_IN_W-1:0] slot,
                           logic [31:0] cur, logic [31:0] num, logic [31:0] den);
    int gap;
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(1, gap_max);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_slot <= slot;
    in_current_value <= cur;
    in_numerator_acc <= num;
    in_denominator_acc <= den;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_updates.insert(pending_updates.size(), predict_update(op, slot, cur, num, den));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_RATE_GEN:  m_rate_gen = data;
      CFG_RATE_MEAN: m_rate_mean = data;
      CFG_RATE_COV:  m_rate_cov = data;
      CFG_W_MEAN:    m_w_mean = data;
      CFG_W_COV:     m_w_cov = data;
      CFG_FLOOR:     m_floor = data[FLOOR_W-1:0];
      CFG_MODE:      m_mode = data[MODE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [31:0] rg, logic [31:0] rm, logic [31:0] rc,
                         logic [31:0] wm, logic [31:0] wc, logic [31:0] fl,
                         logic [31:0] md);
    write_reg(CFG_RATE_GEN, rg);
    write_reg(CFG_RATE_MEAN, rm);
    write_reg(CFG_RATE_COV, rc);
    write_reg(CFG_W_MEAN, wm);
    write_reg(CFG_W_COV, wc);
    write_reg(CFG_FLOOR, fl);
    write_reg(CFG_MODE, md);
  endtask

  task automatic test_reset_defaults();
    send_item(OP_MEAN, 12'd0, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    send_item(OP_MEAN, 12'd0, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    send_item(OP_MEAN, 12'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(OP_MEAN, 12'd2, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(OP_VAR, 12'd3, 32'h0000_0010, 32'h8000_0000, 32'h0);
    send_item(OP_VAR, 12'd4, 32'h0010_0000, 32'h0001_0000, 32'h0);
    send_item(OP_TABLE, 12'd5, 32'h0000_8000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(OP_DIST, 12'hFFF, 32'hFFFF_0000, 32'h1234, 32'h5678);
  endtask

  task automatic test_all_kinds();
    set_all(32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_FFFF, 32'h0,
            32'h7FFF_FFFF, 32'hF);
    send_item(OP_TABLE, 12'd6, 32'h0000_1000, 32'h0, 32'h0001_0000);
    send_item(OP_DIST, 12'd7, 32'h0000_1000, 32'h0001_0000, 32'h0);
    send_item(OP_VAR, 12'd8, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_item(OP_MEAN, 12'd9, 32'h0, 32'h0, 32'h8000_0000);
    send_item(OP_DIST, 12'd7, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(OP_DIST, 12'd7, 32'h0, 32'h0001_0000, 32'h0);
    send_item(OP_DIST, 12'd7, 32'h0, 32'h0001_0000, 32'h0);
  endtask

  task automatic test_adaptive_off();
    set_all(32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 32'hE);
    send_item(OP_MEAN, 12'd10, 32'h0, 32'h7FFF_FFFF, 32'h0);
    send_item(OP_MEAN, 12'd10, 32'h8000_0000, 32'h8000_0000, 32'h0);
    send_item(OP_VAR, 12'd11, 32'h0, 32'h8000_0000, 32'h0);
    send_item(OP_TABLE, 12'd12, 32'h1234_5678, 32'h7FFF_FFFF, 32'h0);
    send_item(OP_MEAN, 12'd10, 32'h0001_0000, 32'h0001_0000, 32'h0);
  endtask

  task automatic test_random(int n, int sm, int gm);
    logic [SLOT_IN_W-1:0] slot;
    stall_mode = sm;
    gap_max = gm;
    for (int i = 0; i < n; i++) begin
      slot = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 7));
      send_item(2'($urandom), slot, rand_val(), rand_val(), rand_val());
    end
  endtask

  // checker
  always @(posedge clk) begin
    upd_t exp_u;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_updates.size() == 0) begin
        $display("%0t: unexpected item new_value=%h limited=%b", $time, out_new_value,
                 out_limited);
        fail_count++;
      end else begin
        exp_u = pending_updates.pop_front();
        if (out_new_value !== exp_u.new_value) begin
          $display("%0t: new_value expected %h actual %h", $time, exp_u.new_value,
                   out_new_value);
          fail_count++;
        end
        if (out_limited !== exp_u.limited) begin
          $display("%0t: limited expected %b actual %b", $time, exp_u.limited, out_limited);
          fail_count++;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    cyc <= cyc + 1;
    case (stall_mode)
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= ((cyc % 7) >= 4);
      3: out_stall <= ($urandom_range(0, 99) < 85);
      default: out_stall <= 1'b0;
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WD_LIMIT) begin
      $display("adagrad_parameter_update_top verification failed");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= OP_MEAN;
    in_slot <= '0;
    in_current_value <= '0;
    in_numerator_acc <= '0;
    in_denominator_acc <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_RATE_GEN;
    cfg_data <= '0;
    m_rate_gen = RATE_RST;
    m_rate_mean = RATE_RST;
    m_rate_cov = RATE_RST;
    m_w_mean = WEIGHT_RST;
    m_w_cov = WEIGHT_RST;
    m_floor = FLOOR_RST;
    m_mode = MODE_RST;
    for (int i = 0; i < SLOTS_DEF; i++) scale_mem[i] = 32'h0001_0000;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_all_kinds();
    test_adaptive_off();
    set_all(RATE_RST, RATE_RST, RATE_RST, WEIGHT_RST, WEIGHT_RST, FLOOR_RST, 32'hF);
    test_random(330, 0, 0);
    set_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 32'hB);
    test_random(330, 1, 6);
    set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'h7FFF_FFFF, 32'h7);
    test_random(320, 2, 3);
    set_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    test_random(320, 3, 10);
    set_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 32'hE);
    test_random(320, 1, 0);
    set_all(32'h0000_4000, 32'h0002_0000, 32'h0000_0100, 32'h0000_8000, 32'h0003_0000,
            32'h0000_1000, 32'hD);
    test_random(330, 0, 4);
    drain();
    if (fail_count == 0)
      $display("adagrad_parameter_update_top verification clean");
    else
      $display("adagrad_parameter_update_top verification failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/agp_pkg.sv
rtl/agp_div.sv
rtl/agp_sqrt.sv
rtl/agp_store.sv
rtl/adagrad_parameter_update_top.sv
sim/tb_adagrad_parameter_update_top.sv
